/* rtl/cst_pkg.sv */
package cst_pkg;

    typedef enum logic [1:0] {
        KIND_PTR   = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_CNT_RD,
        ST_CNT_WAIT,
        ST_CNT_INC,
        ST_SUM_RD,
        ST_SUM_WR,
        ST_SC_RD,
        ST_SC_WAIT,
        ST_SC_WR,
        ST_ISSUE
    } t_state;

    localparam int unsigned IDX_BITS = 8;
    localparam int unsigned DIM_REG_BITS = 9;
    localparam int unsigned PTR_OUT_BITS = 11;

endpackage

/* rtl/cst_ram.sv */
module cst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/csr_sparse_transpose.sv */
// Channel | valid       | stall       | payload
// in      | i_in_valid  | o_in_stall  | i_action, i_row_index, i_col_index, i_payload
// out     | o_out_valid | i_out_stall | o_kind, o_pointer_value, o_new_col,
//         |             |             | o_entry_payload, o_last_item, o_error_seen
// cfg     | i_cfg_we    | -           | i_cfg_index, i_cfg_data
//
// A fetch while reading issues a read of the pointer or entry memory; the registered
// read waits in a pending stage, then moves into the output register. The first fetch
// after loading runs the transpose: it clears the fill memory, counts each column's
// entries, sums the counts into pointers, then scatters entries into the output memory.
// Reset is synchronous, active low; it clears control state, the memories are not cleared.
// A stalled result holds in the output register; one further fetch waits behind it.
module csr_sparse_transpose #(
    parameter int unsigned MAX_DIM      = 256,
    parameter int unsigned MAX_NNZ      = 1024,
    parameter int unsigned PAYLOAD_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  cst_pkg::t_cfg_index      i_cfg_index,
    input  logic [8:0]               i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_action,
    input  logic [7:0]               i_row_index,
    input  logic [7:0]               i_col_index,
    input  logic [PAYLOAD_BITS-1:0]  i_payload,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_kind,
    output logic [10:0]              o_pointer_value,
    output logic [7:0]               o_new_col,
    output logic [PAYLOAD_BITS-1:0]  o_entry_payload,
    output logic                     o_last_item,
    output logic                     o_error_seen
);
    import cst_pkg::*;

    localparam int unsigned CW  = $clog2(MAX_NNZ + 1);
    localparam int unsigned NAW = $clog2(MAX_NNZ);
    localparam int unsigned PAW = $clog2(MAX_DIM + 1);
    localparam int unsigned FAW = $clog2(MAX_DIM);
    localparam int unsigned PW  = $clog2(MAX_DIM + MAX_NNZ + 2);
    localparam int unsigned EW  = (PAW > DIM_REG_BITS) ? PAW : DIM_REG_BITS;
    localparam int unsigned LW  = 2 * IDX_BITS + PAYLOAD_BITS;
    localparam int unsigned OW  = IDX_BITS + PAYLOAD_BITS;

    t_state r_state, n_state;

    logic [DIM_REG_BITS-1:0] r_num_rows, r_num_cols;
    logic [CW-1:0]           r_count;
    logic                    r_reading;
    logic [PW-1:0]           r_pos;
    logic                    r_error;
    logic [PAW-1:0]          r_c;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_sum;
    logic [IDX_BITS-1:0]     r_col, r_row;
    logic [PAYLOAD_BITS-1:0] r_pay;

    logic                    r_p_valid;
    t_kind                   r_p_kind;
    logic                    r_p_last, r_p_err;

    logic                    r_o_valid;
    t_kind                   r_o_kind;
    logic [PTR_OUT_BITS-1:0] r_o_ptr;
    logic [IDX_BITS-1:0]     r_o_col;
    logic [PAYLOAD_BITS-1:0] r_o_pay;
    logic                    r_o_last, r_o_err;

    logic [EW-1:0]  rows_ext, cols_ext;
    logic [PAW-1:0] rows_eff, cols_eff;
    logic [PW-1:0]  cols1, total;
    logic           in_acc, load_acc, fetch_acc, p_move, fetch_ok, issue, load_bad;
    logic           cfg_hit;
    t_kind          iss_kind;
    logic [NAW-1:0] iss_entry;

    // memory ports
    logic             ld_we, ld_re;
    logic [NAW-1:0]   ld_raddr;
    logic [LW-1:0]    ld_rdata;
    logic             fl_we, fl_re;
    logic [FAW-1:0]   fl_waddr, fl_raddr;
    logic [CW-1:0]    fl_wdata, fl_rdata;
    logic             pt_we;
    logic [PAW-1:0]   pt_waddr;
    logic [CW-1:0]    pt_rdata;
    logic             om_we;
    logic [OW-1:0]    om_rdata;
    logic [IDX_BITS-1:0] ld_col;

    assign rows_ext = EW'(r_num_rows);
    assign cols_ext = EW'(r_num_cols);
    assign rows_eff = (rows_ext > EW'(MAX_DIM)) ? PAW'(MAX_DIM) : PAW'(rows_ext);
    assign cols_eff = (cols_ext > EW'(MAX_DIM)) ? PAW'(MAX_DIM) : PAW'(cols_ext);
    assign cols1    = PW'(cols_eff) + PW'(1);
    assign total    = cols1 + PW'(r_count);

    assign p_move    = r_p_valid && (!r_o_valid || !i_out_stall);
    assign fetch_ok  = !r_p_valid || p_move;
    assign o_in_stall = (r_state != ST_IDLE) || (i_action && !fetch_ok);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign load_acc  = in_acc && !i_action;
    assign fetch_acc = in_acc && i_action;
    assign issue     = (fetch_acc && r_reading) || (r_state == ST_ISSUE && fetch_ok);
    assign cfg_hit   = i_cfg_we;

    // a load while reading starts from an empty matrix
    assign load_bad = (EW'(i_row_index) >= EW'(rows_eff))
                   || (EW'(i_col_index) >= EW'(cols_eff))
                   || (r_reading ? 1'b0 : (r_count == CW'(MAX_NNZ)));
    assign ld_we = load_acc && !load_bad;

    always_comb begin
        priority if (r_pos < cols1) begin
            iss_kind = KIND_PTR;
        end else if (r_pos < total) begin
            iss_kind = KIND_ENTRY;
        end else begin
            iss_kind = KIND_END;
        end
    end
    assign iss_entry = NAW'(r_pos - cols1);
    assign ld_col    = ld_rdata[PAYLOAD_BITS +: IDX_BITS];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (fetch_acc && !r_reading) n_state = ST_CLR;
            ST_CLR:      if (r_c == cols_eff) n_state = ST_CNT_RD;
            ST_CNT_RD:   n_state = (r_n == r_count) ? ST_SUM_RD : ST_CNT_WAIT;
            ST_CNT_WAIT: n_state = ST_CNT_INC;
            ST_CNT_INC:  n_state = ST_CNT_RD;
            ST_SUM_RD:   n_state = (r_c == cols_eff) ? ST_SC_RD : ST_SUM_WR;
            ST_SUM_WR:   n_state = ST_SUM_RD;
            ST_SC_RD:    n_state = (r_n == r_count) ? ST_ISSUE : ST_SC_WAIT;
            ST_SC_WAIT:  n_state = ST_SC_WR;
            ST_SC_WR:    n_state = ST_SC_RD;
            ST_ISSUE:    if (fetch_ok) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        ld_re    = 1'b0;
        ld_raddr = r_n[NAW-1:0];
        fl_we    = 1'b0;
        fl_waddr = r_c[FAW-1:0];
        fl_wdata = '0;
        fl_re    = 1'b0;
        fl_raddr = r_c[FAW-1:0];
        pt_we    = 1'b0;
        pt_waddr = r_c;
        om_we    = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                fl_we = (r_c != cols_eff);
            end
            ST_CNT_RD, ST_SC_RD: begin
                ld_re = (r_n != r_count);
            end
            ST_CNT_WAIT, ST_SC_WAIT: begin
                fl_re    = 1'b1;
                fl_raddr = FAW'(ld_col);
            end
            ST_CNT_INC: begin
                fl_we    = 1'b1;
                fl_waddr = FAW'(r_col);
                fl_wdata = fl_rdata + CW'(1);
            end
            ST_SUM_RD: begin
                fl_re = (r_c != cols_eff);
                pt_we = (r_c == cols_eff);
            end
            ST_SUM_WR: begin
                fl_we    = 1'b1;
                fl_wdata = r_sum;
                pt_we    = 1'b1;
            end
            ST_SC_WR: begin
                fl_we    = 1'b1;
                fl_waddr = FAW'(r_col);
                fl_wdata = fl_rdata + CW'(1);
                om_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_num_rows <= DIM_REG_BITS'(1);
            r_num_cols <= DIM_REG_BITS'(1);
            r_count    <= '0;
            r_reading  <= 1'b0;
            r_pos      <= '0;
            r_error    <= 1'b0;
            r_c        <= '0;
            r_n        <= '0;
            r_sum      <= '0;
            r_p_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_hit) begin
                unique case (i_cfg_index)
                    CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
                r_count   <= '0;
                r_reading <= 1'b0;
                r_pos     <= '0;
            end
            if (load_acc) begin
                r_reading <= 1'b0;
                r_pos     <= '0;
                if (load_bad) begin
                    r_error <= 1'b1;
                    if (r_reading) r_count <= '0;
                end else begin
                    r_count <= r_reading ? CW'(1) : r_count + CW'(1);
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_c <= '0;
                end
                ST_CLR: begin
                    if (r_c == cols_eff) begin
                        r_c <= '0;
                        r_n <= '0;
                    end else begin
                        r_c <= r_c + PAW'(1);
                    end
                end
                ST_CNT_RD: begin
                    r_sum <= '0;
                end
                ST_CNT_WAIT, ST_SC_WAIT: begin
                    r_col <= ld_col;
                    r_row <= ld_rdata[PAYLOAD_BITS + IDX_BITS +: IDX_BITS];
                    r_pay <= ld_rdata[PAYLOAD_BITS-1:0];
                end
                ST_CNT_INC, ST_SC_WR: begin
                    r_n <= r_n + CW'(1);
                end
                ST_SUM_RD: begin
                    r_n <= '0;
                end
                ST_SUM_WR: begin
                    r_sum <= r_sum + fl_rdata;
                    r_c   <= r_c + PAW'(1);
                end
                default: begin
                end
            endcase
            if (r_state == ST_ISSUE && fetch_ok) begin
                r_reading <= 1'b1;
            end
            if (issue) begin
                r_p_kind <= iss_kind;
                r_p_last <= (r_pos + PW'(1) == total);
                r_p_err  <= r_error;
                if (r_pos < total) r_pos <= r_pos + PW'(1);
            end
            if (issue) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // output payload, no reset
    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_kind <= r_p_kind;
            r_o_ptr  <= (r_p_kind == KIND_PTR) ? PTR_OUT_BITS'(pt_rdata) : '0;
            r_o_col  <= (r_p_kind == KIND_ENTRY) ? om_rdata[PAYLOAD_BITS +: IDX_BITS] : '0;
            r_o_pay  <= (r_p_kind == KIND_ENTRY) ? om_rdata[PAYLOAD_BITS-1:0] : '0;
            r_o_last <= r_p_last;
            r_o_err  <= r_p_err;
        end
    end

    cst_ram #(.WIDTH(LW), .DEPTH(MAX_NNZ)) u_load_mem (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (r_reading ? NAW'(0) : r_count[NAW-1:0]),
        .i_wdata ({i_row_index, i_col_index, i_payload}),
        .i_re    (ld_re),
        .i_raddr (ld_raddr),
        .o_rdata (ld_rdata)
    );

    cst_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_fill_mem (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_re    (fl_re),
        .i_raddr (fl_raddr),
        .o_rdata (fl_rdata)
    );

    cst_ram #(.WIDTH(CW), .DEPTH(MAX_DIM + 1)) u_ptr_mem (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (r_sum),
        .i_re    (issue && iss_kind == KIND_PTR),
        .i_raddr (PAW'(r_pos)),
        .o_rdata (pt_rdata)
    );

    cst_ram #(.WIDTH(OW), .DEPTH(MAX_NNZ)) u_out_mem (
        .i_clk   (i_clk),
        .i_we    (om_we),
        .i_waddr (fl_rdata[NAW-1:0]),
        .i_wdata ({r_row, r_pay}),
        .i_re    (issue && iss_kind == KIND_ENTRY),
        .i_raddr (iss_entry),
        .o_rdata (om_rdata)
    );

    assign o_out_valid     = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_pointer_value = r_o_ptr;
    assign o_new_col       = r_o_col;
    assign o_entry_payload = r_o_pay;
    assign o_last_item     = r_o_last;
    assign o_error_seen    = r_o_err;

endmodule

/* rtl/cst_chk.sv */
module cst_chk #(
    parameter int unsigned PAYLOAD_BITS = 32
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [1:0]              o_kind,
    input logic [10:0]             o_pointer_value,
    input logic [7:0]              o_new_col,
    input logic [PAYLOAD_BITS-1:0] o_entry_payload,
    input logic                    o_last_item
);
    import cst_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_pointer_value) && $stable(o_entry_payload))
        else $error("stalled result changed");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_END |-> o_pointer_value == '0
            && o_new_col == '0 && o_entry_payload == '0 && !o_last_item)
        else $error("past-end result carries data");

    a_ptr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_PTR |-> o_new_col == '0 && o_entry_payload == '0)
        else $error("pointer result carries entry fields");

endmodule

bind csr_sparse_transpose cst_chk #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cst_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_kind          (o_kind),
    .o_pointer_value (o_pointer_value),
    .o_new_col       (o_new_col),
    .o_entry_payload (o_entry_payload),
    .o_last_item     (o_last_item)
);

/* tb/sv/tb_csr_sparse_transpose.sv */
`timescale 1ns / 100ps

module tb_csr_sparse_transpose;
    import cst_pkg::*;

    localparam int unsigned NNZ_CAP   = 1024;
    localparam int unsigned DIM_CAP   = 256;
    localparam int unsigned RAND_GOAL = 520;
    localparam int unsigned SETTLE    = 20;
    localparam longint unsigned CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        t_kind       kind;
        logic [10:0] ptr;
        logic [7:0]  ncol;
        logic [31:0] pay;
        logic        last;
        logic        err;
    } t_fetch_result;

    typedef struct {
        bit            is_cfg;
        t_cfg_index    idx;
        logic [8:0]    data;
        logic          act;
        logic [7:0]    row;
        logic [7:0]    col;
        logic [31:0]   pay;
        bit            typed;
        t_fetch_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_index  i_cfg_index;
    logic [8:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [7:0]  i_row_index;
    logic [7:0]  i_col_index;
    logic [31:0] i_payload;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [10:0] o_pointer_value;
    logic [7:0]  o_new_col;
    logic [31:0] o_entry_payload;
    logic        o_last_item;
    logic        o_error_seen;

    csr_sparse_transpose dut (.*);

    // transpose predictor state
    logic [7:0]  held_row [NNZ_CAP];
    logic [7:0]  held_col [NNZ_CAP];
    logic [31:0] held_pay [NNZ_CAP];
    int unsigned row_ptr [DIM_CAP+1];
    logic [7:0]  tr_col [NNZ_CAP];
    logic [31:0] tr_pay [NNZ_CAP];
    int unsigned n_held;
    bit          reading;
    int unsigned rd_pos;
    bit          sticky_err;
    int unsigned reg_rows;
    int unsigned reg_cols;

    t_fetch_result pending_results[$];
    int unsigned   mismatches;
    longint unsigned cycles;
    bit          quiet;
    int unsigned stall_run;
    int unsigned rand_items;
    t_stim_row   directed[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned dim_eff(int unsigned v);
        return (v > DIM_CAP) ? DIM_CAP : v;
    endfunction

    function automatic void clear_held();
        n_held  = 0;
        reading = 1'b0;
        rd_pos  = 0;
    endfunction

    function automatic void build_transpose();
        int unsigned cols;
        int unsigned sum;
        int unsigned cnt;
        int unsigned fill [DIM_CAP];
        cols = dim_eff(reg_cols);
        sum  = 0;
        for (int i = 0; i <= DIM_CAP; i++) row_ptr[i] = 0;
        for (int n = 0; n < n_held; n++)
            if (held_col[n] < cols) row_ptr[held_col[n]]++;
        for (int c = 0; c < cols; c++) begin
            cnt = row_ptr[c];
            row_ptr[c] = sum;
            fill[c] = sum;
            sum += cnt;
        end
        row_ptr[cols] = sum;
        // stable scatter: load order kept within each column
        for (int n = 0; n < n_held; n++) begin
            if (held_col[n] < cols && fill[held_col[n]] < NNZ_CAP) begin
                tr_col[fill[held_col[n]]] = held_row[n];
                tr_pay[fill[held_col[n]]] = held_pay[n];
                fill[held_col[n]]++;
            end
        end
    endfunction

    function automatic void take_load(logic [7:0] row, logic [7:0] col, logic [31:0] pay);
        if (reading) clear_held();
        if (row >= dim_eff(reg_rows) || col >= dim_eff(reg_cols) || n_held >= NNZ_CAP) begin
            sticky_err = 1'b1;
        end else begin
            held_row[n_held] = row;
            held_col[n_held] = col;
            held_pay[n_held] = pay;
            n_held++;
        end
    endfunction

    function automatic int unsigned total_results();
        return dim_eff(reg_cols) + 1 + n_held;
    endfunction

    function automatic t_fetch_result transpose_fetch();
        t_fetch_result r;
        int unsigned   nptr;
        if (!reading) begin
            build_transpose();
            reading = 1'b1;
            rd_pos  = 0;
        end
        nptr = dim_eff(reg_cols) + 1;
        r = '{kind: KIND_END, ptr: '0, ncol: '0, pay: '0, last: 1'b0, err: sticky_err};
        if (rd_pos < nptr) begin
            r.kind = KIND_PTR;
            r.ptr  = row_ptr[rd_pos][10:0];
        end else if (rd_pos < total_results()) begin
            r.kind = KIND_ENTRY;
            r.ncol = tr_col[rd_pos - nptr];
            r.pay  = tr_pay[rd_pos - nptr];
        end
        if (rd_pos < total_results()) begin
            r.last = (rd_pos + 1 == total_results());
            rd_pos++;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver back-pressure, with stretches of none
    always @(negedge i_clk) begin
        int unsigned r;
        if (quiet) begin
            i_out_stall = 1'b0;
        end else if (stall_run != 0) begin
            stall_run--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                i_out_stall = 1'b0;
                stall_run = $urandom_range(0, 3);
            end else if (r < 94) begin
                i_out_stall = 1'b1;
                stall_run = $urandom_range(0, 2);
            end else begin
                i_out_stall = 1'b1;
                stall_run = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        t_fetch_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d ptr=%0d", o_kind, o_pointer_value);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_pointer_value !== want.ptr ||
                    o_new_col !== want.ncol || o_entry_payload !== want.pay ||
                    o_last_item !== want.last || o_error_seen !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp k=%0d p=%0d c=%0d d=%h l=%b e=%b",
                                 want.kind, want.ptr, want.ncol, want.pay, want.last,
                                 want.err);
                        $display("         got k=%0d p=%0d c=%0d d=%h l=%b e=%b",
                                 o_kind, o_pointer_value, o_new_col, o_entry_payload,
                                 o_last_item, o_error_seen);
                    end
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_item(logic act, logic [7:0] row, logic [7:0] col, logic [31:0] pay,
                              bit typed, t_fetch_result want);
        int unsigned   gap;
        t_fetch_result got;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action    = act;
        i_row_index = row;
        i_col_index = col;
        i_payload   = pay;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (act) begin
            got = transpose_fetch();
            pending_results.insert(pending_results.size(), typed ? want : got);
        end else begin
            take_load(row, col, pay);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_to_idle();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [8:0] data);
        drain_to_idle();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_NUM_ROWS) reg_rows = data;
        else reg_cols = data;
        clear_held();
    endtask

    function automatic void add_load(logic [7:0] row, logic [7:0] col, logic [31:0] pay);
        directed.insert(directed.size(), '{is_cfg: 0, idx: CFG_NUM_ROWS, data: 0, act: 1'b0,
                        row: row, col: col, pay: pay, typed: 0, want: '0});
    endfunction

    function automatic void add_fetch(bit typed, t_fetch_result want);
        directed.insert(directed.size(), '{is_cfg: 0, idx: CFG_NUM_ROWS, data: 0, act: 1'b1,
                        row: 0, col: 0, pay: 0, typed: typed, want: want});
    endfunction

    function automatic void add_cfg(t_cfg_index idx, logic [8:0] data);
        directed.insert(directed.size(), '{is_cfg: 1, idx: idx, data: data, act: 1'b0,
                        row: 0, col: 0, pay: 0, typed: 0, want: '0});
    endfunction

    function automatic t_fetch_result res(t_kind k, logic last, logic err);
        return '{kind: k, ptr: '0, ncol: '0, pay: '0, last: last, err: err};
    endfunction

    function automatic logic [8:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)  return 9'd0;
        if (r < 14) return 9'd256;
        if (r < 20) return 9'($urandom_range(257, 511));
        if (r < 30) return 9'($urandom_range(9, 255));
        return 9'($urandom_range(1, 8));
    endfunction

    initial begin
        int unsigned nl;
        int unsigned nf;
        logic [7:0]  r8;
        logic [7:0]  c8;
        t_fetch_result none;
        none = '0;
        cycles = 0;
        mismatches = 0;
        quiet = 1'b0;
        stall_run = 0;
        rand_items = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_NUM_ROWS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_action = 1'b0;
        i_row_index = '0;
        i_col_index = '0;
        i_payload = '0;
        i_out_stall = 1'b0;
        reg_rows = 1;
        reg_cols = 1;
        sticky_err = 1'b0;
        clear_held();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty fetch at reset sizes, then past the end
        add_fetch(1, res(KIND_PTR, 1'b0, 1'b0));
        add_fetch(1, res(KIND_PTR, 1'b1, 1'b0));
        add_fetch(1, res(KIND_END, 1'b0, 1'b0));
        // load after fetching restarts the matrix
        add_load(8'd0, 8'd0, 32'hFFFF_FFFF);
        add_fetch(0, none);
        add_fetch(0, none);
        add_fetch(0, none);
        // out-of-range row: dropped, flag sticks
        add_load(8'd1, 8'd0, 32'h0);
        add_fetch(1, res(KIND_PTR, 1'b0, 1'b1));
        add_fetch(1, res(KIND_PTR, 1'b1, 1'b1));
        add_cfg(CFG_NUM_ROWS, 9'd511);
        add_cfg(CFG_NUM_COLS, 9'd256);
        add_load(8'd255, 8'd255, 32'h0);
        add_load(8'd255, 8'd0, 32'hA5A5_A5A5);
        add_load(8'd0, 8'd255, 32'h5A5A_5A5A);
        add_load(8'd3, 8'd7, 32'h1);
        add_fetch(0, none);
        add_fetch(0, none);
        // zero columns: every load dropped, one zero pointer
        add_cfg(CFG_NUM_COLS, 9'd0);
        add_load(8'd0, 8'd0, 32'h1234_5678);
        add_fetch(1, res(KIND_PTR, 1'b1, 1'b1));
        add_fetch(1, res(KIND_END, 1'b0, 1'b1));
        add_cfg(CFG_NUM_ROWS, 9'd2);
        add_cfg(CFG_NUM_COLS, 9'd3);
        add_load(8'd1, 8'd2, 32'hDEAD_BEEF);
        add_load(8'd0, 8'd2, 32'h0BAD_F00D);
        add_load(8'd1, 8'd0, 32'h8000_0001);
        repeat (8) add_fetch(0, none);

        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                write_reg(directed[i].idx, directed[i].data);
            else
                drive_item(directed[i].act, directed[i].row, directed[i].col,
                           directed[i].pay, directed[i].typed, directed[i].want);
        end

        while (rand_items < RAND_GOAL) begin
            if (rand_items == 0 || $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: write_reg(CFG_NUM_ROWS, pick_dim());
                    1: write_reg(CFG_NUM_COLS, pick_dim());
                    default: begin
                        write_reg(CFG_NUM_ROWS, pick_dim());
                        write_reg(CFG_NUM_COLS, pick_dim());
                    end
                endcase
            end
            if ($urandom_range(0, 9) == 0) quiet = ~quiet;
            nl = $urandom_range(0, 14);
            repeat (nl) begin
                if ($urandom_range(0, 9) != 0 && reg_rows != 0 && reg_cols != 0) begin
                    r8 = 8'($urandom_range(0, dim_eff(reg_rows) - 1));
                    c8 = 8'($urandom_range(0, dim_eff(reg_cols) - 1));
                end else begin
                    r8 = 8'($urandom);
                    c8 = 8'($urandom);
                end
                drive_item(1'b0, r8, c8, $urandom(), 0, none);
                rand_items++;
            end
            if (total_results() <= 40 && $urandom_range(0, 9) < 8)
                nf = total_results() + $urandom_range(0, 2);
            else
                nf = $urandom_range(1, 6);
            repeat (nf) begin
                drive_item(1'b1, 8'($urandom), 8'($urandom), $urandom(), 0, none);
                rand_items++;
            end
        end

        quiet = 1'b0;
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/cst_pkg.sv
rtl/cst_ram.sv
rtl/csr_sparse_transpose.sv
rtl/cst_chk.sv
tb/sv/tb_csr_sparse_transpose.sv
